// ===== hdl/busy_idle_load_monitor_unit_defines.svh =====
// Assertion macros shared by the busy/idle load monitor RTL.
`ifndef BUSY_IDLE_LOAD_MONITOR_UNIT_DEFINES_SVH
`define BUSY_IDLE_LOAD_MONITOR_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that holds at every clock edge out of reset.
`define BILM_ASSERT_ALWAYS(label, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("load monitor assertion failed");

// Consequent that holds in the same cycle as the antecedent.
`define BILM_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("load monitor assertion failed");

// Consequent that holds in the cycle after the antecedent.
`define BILM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("load monitor assertion failed");

`else

`define BILM_ASSERT_ALWAYS(label, cond)
`define BILM_ASSERT_IMPLY(label, ante, cons)
`define BILM_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hdl/bilm_pkg.sv =====
// Package with the shared types and constants of the busy/idle load monitor.
`timescale 1ns / 1ps

package bilm_pkg;

  // Field widths of the items and registers.
  localparam int CMD_W      = 2;
  localparam int TIME_W     = 48;
  localparam int DUR_W      = 32;
  localparam int PCT_W      = 7;
  localparam int MAXREC_W   = 6;
  localparam int WINDOW_W   = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;

  // Quotient bits of the percent divider.
  localparam int QUOT_W  = 7;
  localparam int QBIT_W  = 3;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_GO_IDLE = 2'd0;
  localparam logic [CMD_W-1:0] CMD_WAKE    = 2'd1;
  localparam logic [CMD_W-1:0] CMD_QUERY   = 2'd2;

  // Register indexes, taken from paddr[2].
  localparam logic REG_MAX_RECORDS = 1'b0;
  localparam logic REG_WINDOW      = 1'b1;

  // Register reset values.
  localparam logic [MAXREC_W-1:0] MAX_RECORDS_RST = 6'd32;
  localparam logic [WINDOW_W-1:0] WINDOW_RST      = 32'd2000000;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_STORE,
    ST_PREP,
    ST_SUM,
    ST_EV_CHK,
    ST_EV_SUB,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

// ===== hdl/bilm_in_if.sv =====
// Input channel of the load monitor: command and current time.
`timescale 1ns / 1ps

interface bilm_in_if;
  logic                         valid;
  logic                         ready;
  logic [bilm_pkg::CMD_W-1:0]   command;
  logic [bilm_pkg::TIME_W-1:0]  now_usec;

  modport source (output valid, output command, output now_usec, input ready);
  modport sink   (input valid, input command, input now_usec, output ready);
endinterface

// ===== hdl/bilm_out_if.sv =====
// Result channel of the load monitor: busy share in percent.
`timescale 1ns / 1ps

interface bilm_out_if;
  logic                        valid;
  logic                        ready;
  logic [bilm_pkg::PCT_W-1:0]  load_percent;

  modport source (output valid, output load_percent, input ready);
  modport sink   (input valid, input load_percent, output ready);
endinterface

// ===== hdl/bilm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
`timescale 1ns / 1ps

module bilm_ram #(
  parameter int WIDTH = 33,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/busy_idle_load_monitor_unit.sv =====
// Top level of the busy/idle load monitor with its record ring and percent divider.
//
//   channel   direction  handshake            payload
//   in_ch     sink       valid/ready          command, now_usec
//   out_ch    source     valid/ready          load_percent
//   cfg_*     slave      APB psel/penable     max_records (0x0), window_usec (0x4)
//
// A go-idle or wake item is accepted, then written into the record RAM unless the limit is zero.
// A query walks the stored records, evicts the oldest ones and then divides:
// the sum walks the RAM one record a cycle, each eviction is a read and a subtract,
// and the percent comes from a 7-step restoring divider.
// The result waits in an output register; a new item is taken while it waits.
// Reset is synchronous; the ring needs no clearing pass, only counted entries are read.
`timescale 1ns / 1ps
`include "busy_idle_load_monitor_unit_defines.svh"

module busy_idle_load_monitor_unit #(
  parameter int RECORD_DEPTH = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bilm_in_if.sink                           in_ch,
  bilm_out_if.source                        out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [bilm_pkg::CFG_ADDR_W-1:0]   cfg_paddr,
  input  logic [bilm_pkg::CFG_DATA_W-1:0]   cfg_pwdata,
  output logic [bilm_pkg::CFG_DATA_W-1:0]   cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W  = $clog2(RECORD_DEPTH);
  localparam int CNT_W  = $clog2(RECORD_DEPTH + 1);
  localparam int SUM_W  = bilm_pkg::DUR_W + $clog2(RECORD_DEPTH + 2);
  localparam int PROD_W = SUM_W + bilm_pkg::QUOT_W;
  localparam int LIM_W  = (CNT_W > bilm_pkg::MAXREC_W) ? CNT_W : bilm_pkg::MAXREC_W;
  localparam int MEM_W  = bilm_pkg::DUR_W + 1;

  bilm_pkg::state_t state_r, state_nxt;

  logic [bilm_pkg::CMD_W-1:0]    cmd_r, cmd_nxt;
  logic [bilm_pkg::TIME_W-1:0]   now_r, now_nxt;
  logic                          is_idle_r, is_idle_nxt;
  logic [bilm_pkg::TIME_W-1:0]   idle_since_r, idle_since_nxt;
  logic [bilm_pkg::TIME_W-1:0]   busy_since_r, busy_since_nxt;
  logic [IDX_W-1:0]              oldest_r, oldest_nxt;
  logic [CNT_W-1:0]              count_r, count_nxt;
  logic [bilm_pkg::MAXREC_W-1:0] max_records_r;
  logic [bilm_pkg::WINDOW_W-1:0] window_r;
  logic [IDX_W-1:0]              ptr_r, ptr_nxt;
  logic [CNT_W-1:0]              issue_cnt_r, issue_cnt_nxt;
  logic                          rd_vld_r, rd_vld_nxt;
  logic [SUM_W-1:0]              busy_r, busy_nxt;
  logic [SUM_W-1:0]              idle_r, idle_nxt;
  logic [SUM_W-1:0]              total_r, total_nxt;
  logic [PROD_W-1:0]             rem_r, rem_nxt;
  logic [bilm_pkg::QUOT_W-1:0]   quot_r, quot_nxt;
  logic [bilm_pkg::QBIT_W-1:0]   bit_r, bit_nxt;
  logic                          out_vld_r, out_vld_nxt;
  logic [bilm_pkg::PCT_W-1:0]    load_r, load_nxt;

  logic                          in_acc;
  logic                          cfg_wr;
  logic [CNT_W-1:0]              limit;
  logic                          evict;
  logic                          sum_done;
  logic                          out_free;

  // Store-path signals.
  logic [bilm_pkg::DUR_W-1:0]    store_len;
  logic                          store_drop;
  logic [IDX_W-1:0]              store_oldest;
  logic [CNT_W-1:0]              store_count;
  logic [IDX_W:0]                store_sum;
  logic [IDX_W-1:0]              store_slot;

  // Divider step.
  logic [PROD_W-1:0]             div_cand;
  logic [PROD_W-1:0]             busy_ext;

  // Record RAM ports.
  logic                          mem_we;
  logic [IDX_W-1:0]              mem_waddr;
  logic [MEM_W-1:0]              mem_wdata;
  logic                          mem_re;
  logic [IDX_W-1:0]              mem_raddr;
  logic [MEM_W-1:0]              mem_rdata;
  logic [bilm_pkg::DUR_W-1:0]    rd_len;
  logic                          rd_idle;

  // Duration from since to now, zero when time went backward, saturated to 32 bits.
  function automatic logic [bilm_pkg::DUR_W-1:0] span(
    input logic [bilm_pkg::TIME_W-1:0] now,
    input logic [bilm_pkg::TIME_W-1:0] since
  );
    logic [bilm_pkg::TIME_W-1:0] d;
    d = now - since;
    if (now < since) begin
      span = '0;
    end else if (d[bilm_pkg::TIME_W-1:bilm_pkg::DUR_W] != '0) begin
      span = '1;
    end else begin
      span = d[bilm_pkg::DUR_W-1:0];
    end
  endfunction

  // Ring index increment with wrap at the ring depth.
  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] idx);
    if (idx == IDX_W'(RECORD_DEPTH - 1)) begin
      wrap_inc = '0;
    end else begin
      wrap_inc = idx + 1'b1;
    end
  endfunction

  assign in_acc   = in_ch.valid && in_ch.ready;
  assign cfg_wr   = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign out_free = !out_vld_r || out_ch.ready;

  // Effective record limit: the register clipped to the ring depth.
  always_comb begin
    if (LIM_W'(max_records_r) > LIM_W'(RECORD_DEPTH)) begin
      limit = CNT_W'(RECORD_DEPTH);
    end else begin
      limit = CNT_W'(max_records_r);
    end
  end

  // Configuration registers and read mux.
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_records_r <= bilm_pkg::MAX_RECORDS_RST;
      window_r      <= bilm_pkg::WINDOW_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[2])
        bilm_pkg::REG_MAX_RECORDS: max_records_r <= cfg_pwdata[bilm_pkg::MAXREC_W-1:0];
        bilm_pkg::REG_WINDOW:      window_r      <= cfg_pwdata[bilm_pkg::WINDOW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[2])
      bilm_pkg::REG_MAX_RECORDS: cfg_prdata = bilm_pkg::CFG_DATA_W'(max_records_r);
      bilm_pkg::REG_WINDOW:      cfg_prdata = window_r;
      default:                   cfg_prdata = '0;
    endcase
  end

  // Record storage: flag in the top bit, duration below.
  bilm_ram #(
    .WIDTH (MEM_W),
    .DEPTH (RECORD_DEPTH)
  ) u_ring (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  assign rd_len  = mem_rdata[bilm_pkg::DUR_W-1:0];
  assign rd_idle = mem_rdata[bilm_pkg::DUR_W];

  // Store path: drop the oldest record when full, then append at the tail.
  always_comb begin
    if (cmd_r == bilm_pkg::CMD_GO_IDLE) begin
      store_len = span(now_r, busy_since_r);
    end else begin
      store_len = span(now_r, idle_since_r);
    end
    store_drop   = (count_r >= limit) && (count_r != '0);
    store_oldest = store_drop ? wrap_inc(oldest_r) : oldest_r;
    store_count  = store_drop ? (count_r - 1'b1) : count_r;
    store_sum    = {1'b0, store_oldest} + (IDX_W + 1)'(store_count);
    if (store_sum >= (IDX_W + 1)'(RECORD_DEPTH)) begin
      store_slot = IDX_W'(store_sum - (IDX_W + 1)'(RECORD_DEPTH));
    end else begin
      store_slot = IDX_W'(store_sum);
    end
  end

  // Query control terms.
  assign sum_done = (issue_cnt_r == count_r) && !rd_vld_r;
  assign evict    = (count_r != '0) &&
                    ((total_r > SUM_W'(window_r)) || (count_r > limit));
  assign div_cand = PROD_W'(total_r) << bit_r;
  assign busy_ext = PROD_W'(busy_r);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      bilm_pkg::ST_IDLE: begin
        if (in_acc) begin
          case (in_ch.command)
            bilm_pkg::CMD_GO_IDLE, bilm_pkg::CMD_WAKE: state_nxt = bilm_pkg::ST_STORE;
            bilm_pkg::CMD_QUERY:                       state_nxt = bilm_pkg::ST_PREP;
            default:                                   state_nxt = bilm_pkg::ST_IDLE;
          endcase
        end
      end
      bilm_pkg::ST_STORE:  state_nxt = bilm_pkg::ST_IDLE;
      bilm_pkg::ST_PREP:   state_nxt = bilm_pkg::ST_SUM;
      bilm_pkg::ST_SUM: begin
        if (sum_done) begin
          state_nxt = bilm_pkg::ST_EV_CHK;
        end
      end
      bilm_pkg::ST_EV_CHK: state_nxt = evict ? bilm_pkg::ST_EV_SUB : bilm_pkg::ST_MUL;
      bilm_pkg::ST_EV_SUB: state_nxt = bilm_pkg::ST_EV_CHK;
      bilm_pkg::ST_MUL:    state_nxt = bilm_pkg::ST_DIV;
      bilm_pkg::ST_DIV: begin
        if (bit_r == '0) begin
          state_nxt = bilm_pkg::ST_DONE;
        end
      end
      bilm_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = bilm_pkg::ST_IDLE;
        end
      end
      default:             state_nxt = bilm_pkg::ST_IDLE;
    endcase
  end

  // Handshake and RAM controls per state.
  always_comb begin
    in_ch.ready = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = store_slot;
    mem_wdata   = {cmd_r == bilm_pkg::CMD_WAKE, store_len};
    mem_re      = 1'b0;
    mem_raddr   = ptr_r;
    case (state_r)
      bilm_pkg::ST_IDLE:   in_ch.ready = 1'b1;
      bilm_pkg::ST_STORE:  mem_we = (limit != '0);
      bilm_pkg::ST_SUM:    mem_re = (issue_cnt_r != count_r);
      bilm_pkg::ST_EV_CHK: begin
        mem_re    = evict;
        mem_raddr = oldest_r;
      end
      default: ;
    endcase
  end

  assign out_ch.valid        = out_vld_r;
  assign out_ch.load_percent = load_r;

  // Datapath next values.
  always_comb begin
    cmd_nxt        = cmd_r;
    now_nxt        = now_r;
    is_idle_nxt    = is_idle_r;
    idle_since_nxt = idle_since_r;
    busy_since_nxt = busy_since_r;
    oldest_nxt     = oldest_r;
    count_nxt      = count_r;
    ptr_nxt        = ptr_r;
    issue_cnt_nxt  = issue_cnt_r;
    rd_vld_nxt     = 1'b0;
    busy_nxt       = busy_r;
    idle_nxt       = idle_r;
    total_nxt      = total_r;
    rem_nxt        = rem_r;
    quot_nxt       = quot_r;
    bit_nxt        = bit_r;
    out_vld_nxt    = out_vld_r && !out_ch.ready;
    load_nxt       = load_r;
    case (state_r)
      bilm_pkg::ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt = in_ch.command;
          now_nxt = in_ch.now_usec;
        end
      end
      bilm_pkg::ST_STORE: begin
        if (cmd_r == bilm_pkg::CMD_GO_IDLE) begin
          is_idle_nxt    = 1'b1;
          idle_since_nxt = now_r;
        end else begin
          is_idle_nxt    = 1'b0;
          busy_since_nxt = now_r;
        end
        // A zero limit keeps no records at all.
        if (limit == '0) begin
          oldest_nxt = '0;
          count_nxt  = '0;
        end else begin
          oldest_nxt = store_oldest;
          count_nxt  = store_count + 1'b1;
        end
      end
      bilm_pkg::ST_PREP: begin
        // Seed the sums with the open interval up to now.
        if (is_idle_r) begin
          busy_nxt = '0;
          idle_nxt = SUM_W'(span(now_r, idle_since_r));
        end else begin
          busy_nxt = SUM_W'(span(now_r, busy_since_r));
          idle_nxt = '0;
        end
        ptr_nxt       = oldest_r;
        issue_cnt_nxt = '0;
      end
      bilm_pkg::ST_SUM: begin
        // One read issued and one record added per cycle.
        if (issue_cnt_r != count_r) begin
          ptr_nxt       = wrap_inc(ptr_r);
          issue_cnt_nxt = issue_cnt_r + 1'b1;
          rd_vld_nxt    = 1'b1;
        end
        if (rd_vld_r) begin
          if (rd_idle) begin
            idle_nxt = idle_r + SUM_W'(rd_len);
          end else begin
            busy_nxt = busy_r + SUM_W'(rd_len);
          end
        end
        if (sum_done) begin
          total_nxt = busy_r + idle_r;
        end
      end
      bilm_pkg::ST_EV_SUB: begin
        // Remove the oldest record from the sums and the ring.
        if (rd_idle) begin
          idle_nxt = idle_r - SUM_W'(rd_len);
        end else begin
          busy_nxt = busy_r - SUM_W'(rd_len);
        end
        total_nxt  = total_r - SUM_W'(rd_len);
        oldest_nxt = wrap_inc(oldest_r);
        count_nxt  = count_r - 1'b1;
      end
      bilm_pkg::ST_MUL: begin
        // busy * 100 as 64x + 32x + 4x.
        rem_nxt  = (busy_ext << 6) + (busy_ext << 5) + (busy_ext << 2);
        quot_nxt = '0;
        bit_nxt  = bilm_pkg::QBIT_W'(bilm_pkg::QUOT_W - 1);
      end
      bilm_pkg::ST_DIV: begin
        // Restoring division, one quotient bit per cycle.
        if (rem_r >= div_cand) begin
          rem_nxt         = rem_r - div_cand;
          quot_nxt[bit_r] = 1'b1;
        end
        if (bit_r != '0) begin
          bit_nxt = bit_r - 1'b1;
        end
      end
      bilm_pkg::ST_DONE: begin
        if (out_free) begin
          out_vld_nxt = 1'b1;
          load_nxt    = (total_r == '0) ? '0 : quot_r;
        end
      end
      default: ;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= bilm_pkg::ST_IDLE;
      is_idle_r    <= 1'b0;
      idle_since_r <= '0;
      busy_since_r <= '0;
      oldest_r     <= '0;
      count_r      <= '0;
      rd_vld_r     <= 1'b0;
      out_vld_r    <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      is_idle_r    <= is_idle_nxt;
      idle_since_r <= idle_since_nxt;
      busy_since_r <= busy_since_nxt;
      oldest_r     <= oldest_nxt;
      count_r      <= count_nxt;
      rd_vld_r     <= rd_vld_nxt;
      out_vld_r    <= out_vld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    now_r       <= now_nxt;
    ptr_r       <= ptr_nxt;
    issue_cnt_r <= issue_cnt_nxt;
    busy_r      <= busy_nxt;
    idle_r      <= idle_nxt;
    total_r     <= total_nxt;
    rem_r       <= rem_nxt;
    quot_r      <= quot_nxt;
    bit_r       <= bit_nxt;
    load_r      <= load_nxt;
  end

  // Checks on the ring, the RAM port use, the result range and the input stall during a query.
  `BILM_ASSERT_ALWAYS(a_count_bound, count_r <= CNT_W'(RECORD_DEPTH))
  `BILM_ASSERT_ALWAYS(a_no_rw_clash, !(mem_we && mem_re))
  `BILM_ASSERT_IMPLY(a_evict_nonempty, state_r == bilm_pkg::ST_EV_SUB, count_r != '0)
  `BILM_ASSERT_IMPLY(a_pct_range, out_vld_r, load_r <= 7'd100)
  `BILM_ASSERT_NEXT(a_query_busy, in_acc && (in_ch.command == bilm_pkg::CMD_QUERY), !in_ch.ready)

endmodule

// ===== sim/testbench.sv =====
// Self-checking testbench for the busy/idle load monitor with a built-in load predictor.
`timescale 1ns / 1ps

module testbench;
  import bilm_pkg::*;

  // Command code that the block ignores.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  // Depth of the record ring at the default parameter; slot pointers wrap at 5 bits.
  localparam int HIST_DEPTH = 32;
  localparam logic [DUR_W-1:0] DUR_MAX = '1;
  // Cycles to let pass after the last result, longer than the slowest query.
  localparam int SETTLE_CYCLES = 150;
  // Length of the long receiver hold that fills the block up.
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 9;
  localparam int ITEMS_PER_PHASE = 84;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [TIME_W-1:0] now_usec;
  } load_item_t;

  logic clk;
  logic rst_n;

  bilm_in_if  in_ch ();
  bilm_out_if out_ch ();

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  busy_idle_load_monitor_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // Items waiting to be offered, and load figures waiting to come out.
  load_item_t       item_q[$];
  logic [PCT_W-1:0] pct_expect_q[$];

  // Predictor state: record ring, worker state and register shadows.
  logic [DUR_W-1:0]    hist_len [HIST_DEPTH];
  logic                hist_idle [HIST_DEPTH];
  logic [4:0]          hist_head;
  logic [5:0]          hist_count;
  logic                worker_idle;
  logic [TIME_W-1:0]   idle_start;
  logic [TIME_W-1:0]   busy_start;
  logic [MAXREC_W-1:0] lim_records;
  logic [WINDOW_W-1:0] win_usec;

  int send_idle_pct;
  int recv_idle_pct;
  int hold_left;
  int err_count;
  int items_taken;
  int results_checked;
  int settings_done;

  // Stimulus generator state.
  logic [TIME_W-1:0] gen_now;
  logic              gen_idle;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("testbench: FAIL");
    $finish;
  end

  // Duration from a start time to now: zero when time went backward, saturated at 32 bits.
  function automatic logic [DUR_W-1:0] elapsed(input logic [TIME_W-1:0] now_usec,
                                               input logic [TIME_W-1:0] since);
    logic [TIME_W-1:0] d;
    if (now_usec < since) return '0;
    d = now_usec - since;
    return (d > DUR_MAX) ? DUR_MAX : d[DUR_W-1:0];
  endfunction

  // Number of records the ring may hold under the current limit.
  function automatic logic [5:0] record_cap();
    return (lim_records > HIST_DEPTH) ? 6'(HIST_DEPTH) : lim_records;
  endfunction

  // Store one closed interval, dropping at most the oldest record.
  task automatic store_interval(input logic [DUR_W-1:0] len, input logic was_idle);
    logic [5:0] cap;
    logic [4:0] slot;
    cap = record_cap();
    if (cap == 0) begin
      hist_head  = '0;
      hist_count = '0;
    end else begin
      if (hist_count >= cap) begin
        hist_head  = hist_head + 5'd1;
        hist_count = hist_count - 6'd1;
      end
      slot = hist_head + hist_count[4:0];
      hist_len[slot]  = len;
      hist_idle[slot] = was_idle;
      hist_count = hist_count + 6'd1;
    end
  endtask

  // Advance the predicted state by one accepted item; a query queues its load figure.
  task automatic predict_load(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_usec);
    logic [63:0] busy_sum;
    logic [63:0] idle_sum;
    logic [63:0] total;
    logic [63:0] pct;
    logic [5:0]  cap;
    logic [4:0]  slot;
    busy_sum = '0;
    idle_sum = '0;
    case (cmd)
      CMD_GO_IDLE: begin
        store_interval(elapsed(now_usec, busy_start), 1'b0);
        worker_idle = 1'b1;
        idle_start  = now_usec;
      end
      CMD_WAKE: begin
        store_interval(elapsed(now_usec, idle_start), 1'b1);
        worker_idle = 1'b0;
        busy_start  = now_usec;
      end
      CMD_QUERY: begin
        for (int i = 0; i < hist_count; i++) begin
          slot = hist_head + 5'(i);
          if (hist_idle[slot]) idle_sum += hist_len[slot];
          else busy_sum += hist_len[slot];
        end
        // The open interval counts up to now.
        if (worker_idle) idle_sum += elapsed(now_usec, idle_start);
        else busy_sum += elapsed(now_usec, busy_start);
        total = busy_sum + idle_sum;
        // Evict the oldest records until both the window and the count limit hold.
        cap = record_cap();
        while (hist_count != 0 && (total > win_usec || hist_count > cap)) begin
          slot = hist_head;
          if (hist_idle[slot]) idle_sum -= hist_len[slot];
          else busy_sum -= hist_len[slot];
          total -= hist_len[slot];
          hist_head  = hist_head + 5'd1;
          hist_count = hist_count - 6'd1;
        end
        pct = (total == 0) ? 64'd0 : (busy_sum * 100) / total;
        pct_expect_q.push_back(pct[PCT_W-1:0]);
      end
      default: begin
      end
    endcase
  endtask

  // One register transfer: setup cycle, then access cycle until pready.
  task automatic cfg_access(input logic is_write, input logic reg_idx,
                            input logic [CFG_DATA_W-1:0] wdata,
                            output logic [CFG_DATA_W-1:0] rdata);
    @(posedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= is_write;
    cfg_paddr   <= {reg_idx, 2'b00};
    cfg_pwdata  <= wdata;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    rdata = cfg_prdata;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    if (is_write) begin
      if (reg_idx == REG_MAX_RECORDS) lim_records = wdata[MAXREC_W-1:0];
      else win_usec = wdata[WINDOW_W-1:0];
    end
  endtask

  // Read both registers back and compare them with the shadows.
  task automatic check_regs();
    logic [CFG_DATA_W-1:0] rd;
    cfg_access(1'b0, REG_MAX_RECORDS, '0, rd);
    if (rd[MAXREC_W-1:0] !== lim_records) begin
      $error("max_records: expected %0d, actual %0d", lim_records, rd[MAXREC_W-1:0]);
      err_count++;
    end
    cfg_access(1'b0, REG_WINDOW, '0, rd);
    if (rd[WINDOW_W-1:0] !== win_usec) begin
      $error("window_usec: expected %0d, actual %0d", win_usec, rd[WINDOW_W-1:0]);
      err_count++;
    end
  endtask

  // Wait until every item is taken and every result is in, then let the block settle.
  task automatic wait_drained();
    do @(negedge clk);
    while (item_q.size() != 0 || in_ch.valid || pct_expect_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic push_item(input logic [CMD_W-1:0] cmd, input logic [TIME_W-1:0] now_usec);
    load_item_t it;
    it.command  = cmd;
    it.now_usec = now_usec;
    item_q.push_back(it);
  endtask

  // Next time stamp: mostly small steps, sometimes long jumps, backward steps or any value.
  function automatic logic [TIME_W-1:0] next_now();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) gen_now = gen_now - TIME_W'($urandom_range(0, 5000));
    else if (r < 5) gen_now = gen_now + TIME_W'({$urandom_range(0, 15), $urandom});
    else if (r < 6) gen_now = TIME_W'({$urandom, $urandom});
    else gen_now = gen_now + TIME_W'($urandom_range(0, 150000));
    return gen_now;
  endfunction

  // Mostly alternating sleep and wake events with queries, plus repeats and noise.
  task automatic push_random_phase(input int count);
    int taken;
    int r;
    logic [CMD_W-1:0] cmd;
    taken = 0;
    gen_now = TIME_W'($urandom_range(0, 1000));
    while (taken < count) begin
      r = $urandom_range(0, 99);
      if (r < 40) cmd = gen_idle ? CMD_WAKE : CMD_GO_IDLE;
      else if (r < 48) cmd = gen_idle ? CMD_GO_IDLE : CMD_WAKE;
      else if (r < 85) cmd = CMD_QUERY;
      else if (r < 92) cmd = CMD_UNUSED;
      else cmd = CMD_W'($urandom_range(0, 3));
      if (cmd == CMD_GO_IDLE) gen_idle = 1'b1;
      if (cmd == CMD_WAKE) gen_idle = 1'b0;
      if (cmd != CMD_UNUSED) taken++;
      push_item(cmd, next_now());
    end
  endtask

  // Sender: offers queued items, idling at random between them.
  always @(posedge clk) begin : drive_items
    load_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        predict_load(in_ch.command, in_ch.now_usec);
        if (in_ch.command != CMD_UNUSED) items_taken++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (item_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          nxt = item_q[0];
          item_q.delete(0);
          in_ch.valid    <= 1'b1;
          in_ch.command  <= nxt.command;
          in_ch.now_usec <= nxt.now_usec;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each load figure and stalls at random, twice for a long stretch.
  always @(posedge clk) begin : collect_results
    logic [PCT_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      hold_left = 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (pct_expect_q.size() == 0) begin
          $error("load_percent: expected none, actual %0d", out_ch.load_percent);
          err_count++;
        end else begin
          want = pct_expect_q[0];
          pct_expect_q.delete(0);
          if (out_ch.load_percent !== want) begin
            $error("load_percent: expected %0d, actual %0d", want, out_ch.load_percent);
            err_count++;
          end
        end
        results_checked++;
        if (results_checked == 40 || results_checked == 200) hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
      end
    end
  end

  // Main sequence: reset, directed items, then random phases under several settings.
  initial begin : run_phases
    logic [MAXREC_W-1:0]   mr;
    logic [WINDOW_W-1:0]   win;
    logic [CFG_DATA_W-1:0] rd;
    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.command  = '0;
    in_ch.now_usec = '0;
    out_ch.ready   = 1'b0;
    cfg_psel       = 1'b0;
    cfg_penable    = 1'b0;
    cfg_pwrite     = 1'b0;
    cfg_paddr      = '0;
    cfg_pwdata     = '0;
    hist_head      = '0;
    hist_count     = '0;
    worker_idle    = 1'b0;
    idle_start     = '0;
    busy_start     = '0;
    lim_records    = MAX_RECORDS_RST;
    win_usec       = WINDOW_RST;
    send_idle_pct  = 26;
    recv_idle_pct  = 60;
    hold_left      = 0;
    err_count      = 0;
    items_taken    = 0;
    results_checked = 0;
    settings_done  = 0;
    gen_now        = '0;
    gen_idle       = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    check_regs();

    // Directed items under the reset settings.
    push_item(CMD_QUERY, 48'd0);
    push_item(CMD_QUERY, 48'd1000);
    push_item(CMD_GO_IDLE, 48'd1000);
    push_item(CMD_QUERY, 48'd1500);
    push_item(CMD_WAKE, 48'd1500);
    push_item(CMD_UNUSED, 48'd1600);
    push_item(CMD_QUERY, 48'd1600);
    // Repeated sleep and repeated wake.
    push_item(CMD_GO_IDLE, 48'd2000);
    push_item(CMD_GO_IDLE, 48'd2500);
    push_item(CMD_WAKE, 48'd3000);
    push_item(CMD_WAKE, 48'd3200);
    push_item(CMD_QUERY, 48'd3200);
    // Time going backward.
    push_item(CMD_GO_IDLE, 48'd100);
    push_item(CMD_QUERY, 48'd50);
    // Durations past 32 bits and the largest time stamp.
    push_item(CMD_WAKE, 48'h0003_0000_0000);
    push_item(CMD_QUERY, '1);
    push_item(CMD_GO_IDLE, '1);
    push_item(CMD_WAKE, '1);
    push_item(CMD_QUERY, '1);
    push_item(CMD_UNUSED, '1);
    push_item(CMD_QUERY, '1);
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin mr = 6'd32; win = 32'd2000000;    end
        1: begin mr = 6'd1;  win = 32'd1;          end
        2: begin mr = 6'd63; win = 32'hFFFF_FFFF;  end
        3: begin mr = 6'd0;  win = 32'd500000;     end
        4: begin mr = 6'd33; win = 32'd0;          end
        5: begin mr = 6'd8;  win = 32'd300000;     end
        6: begin mr = 6'd16; win = 32'd100000;     end
        7: begin mr = 6'd5;  win = 32'hFFFF_FFFF;  end
        default: begin mr = 6'd32; win = 32'd2000000; end
      endcase
      // Sender idles lightly first, then the receiver does, then neither.
      if (p < 3) begin
        send_idle_pct = 26;
        recv_idle_pct = 60;
      end else if (p < 6) begin
        send_idle_pct = 60;
        recv_idle_pct = 26;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      cfg_access(1'b1, REG_MAX_RECORDS, CFG_DATA_W'(mr), rd);
      cfg_access(1'b1, REG_WINDOW, CFG_DATA_W'(win), rd);
      check_regs();
      settings_done++;
      push_random_phase(ITEMS_PER_PHASE);
      wait_drained();
    end

    $display("testbench: %0d items taken, %0d load figures checked", items_taken,
             results_checked);
    $display("testbench: %0d register settings, limits 0 to 63, windows 0 to 2^32-1",
             settings_done);
    if (err_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
